>>> hw/rtl/mips_subset_instruction_step_core_macros.svh
// Assertion macros for the instruction step core.
`ifndef MIPS_SUBSET_INSTRUCTION_STEP_CORE_MACROS_SVH
`define MIPS_SUBSET_INSTRUCTION_STEP_CORE_MACROS_SVH
// Implication checked on every clock edge, disabled in reset.
`define MSIS_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define MSIS_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/msis_pkg.sv
// Package: constants, types and opcodes of the instruction step core.
`default_nettype none
package msis_pkg;
  localparam int unsigned DataWordsDefault = 1024;
  localparam logic [31:0] StartReset = 32'h0040_0000;
  localparam logic [31:0] GpReset = 32'h1000_8000;
  localparam logic [31:0] SpBase = 32'h1000_0000;

  localparam logic [5:0] OpSpecial = 6'h00;
  localparam logic [5:0] OpJ = 6'h02;
  localparam logic [5:0] OpJal = 6'h03;
  localparam logic [5:0] OpBeq = 6'h04;
  localparam logic [5:0] OpBne = 6'h05;
  localparam logic [5:0] OpAddiu = 6'h09;
  localparam logic [5:0] OpAndi = 6'h0c;
  localparam logic [5:0] OpLui = 6'h0f;
  localparam logic [5:0] OpTrap = 6'h1a;
  localparam logic [5:0] OpLw = 6'h23;
  localparam logic [5:0] OpSw = 6'h2b;

  localparam logic [5:0] FnSll = 6'h00;
  localparam logic [5:0] FnSra = 6'h03;
  localparam logic [5:0] FnJr = 6'h08;
  localparam logic [5:0] FnMfhi = 6'h10;
  localparam logic [5:0] FnMflo = 6'h12;
  localparam logic [5:0] FnMult = 6'h18;
  localparam logic [5:0] FnDiv = 6'h1a;
  localparam logic [5:0] FnAddu = 6'h21;
  localparam logic [5:0] FnSubu = 6'h23;
  localparam logic [5:0] FnSlt = 6'h2a;

  localparam logic [3:0] TrapNewline = 4'h0;
  localparam logic [3:0] TrapPrint = 4'h1;
  localparam logic [3:0] TrapRead = 4'h5;

  localparam logic [1:0] EvNone = 2'd0;
  localparam logic [1:0] EvNewline = 2'd1;
  localparam logic [1:0] EvPrint = 2'd2;
  localparam logic [1:0] EvRead = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [31:0] a;
    logic [31:0] b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hi;
    logic [31:0] lo;
  } md_rsp_t;
endpackage
`default_nettype wire

>>> hw/rtl/msis_muldiv.sv
// Multi-cycle signed multiply and divide unit.
`default_nettype none
`include "mips_subset_instruction_step_core_macros.svh"
module msis_muldiv (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire msis_pkg::md_req_t req,
  output msis_pkg::md_rsp_t    rsp
);
  logic        busy;
  logic        is_div;
  logic [5:0]  count;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] acc;
  logic [31:0] rem;
  logic [31:0] quo;
  logic        neg_q;
  logic        neg_r;
  logic        zero_div;
  logic [32:0] trial;
  logic [32:0] rem_shift;
  logic [63:0] prod;

  assign rem_shift = {rem, ma[31]};
  assign trial = rem_shift - {1'b0, mb};
  assign prod = neg_q ? (64'd0 - acc) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        is_div <= req.is_div;
        count <= 6'd0;
        ma <= req.a[31] ? 32'd0 - req.a : req.a;
        mb <= req.b[31] ? 32'd0 - req.b : req.b;
        neg_q <= req.a[31] ^ req.b[31];
        neg_r <= req.a[31];
        zero_div <= (req.b == 32'd0);
        acc <= 64'd0;
        rem <= 32'd0;
        quo <= 32'd0;
      end else if (busy) begin
        if (count == 6'd32) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          if (is_div) begin
            if (zero_div) begin
              rsp.hi <= 32'd0;
              rsp.lo <= 32'd0;
            end else begin
              rsp.lo <= neg_q ? 32'd0 - quo : quo;
              rsp.hi <= neg_r ? 32'd0 - rem : rem;
            end
          end else begin
            rsp.hi <= prod[63:32];
            rsp.lo <= prod[31:0];
          end
        end else begin
          count <= count + 6'd1;
          if (is_div) begin
            ma <= {ma[30:0], 1'b0};
            if (!trial[32]) begin
              rem <= trial[31:0];
              quo <= {quo[30:0], 1'b1};
            end else begin
              rem <= rem_shift[31:0];
              quo <= {quo[30:0], 1'b0};
            end
          end else begin
            acc <= {acc[62:0], 1'b0} + (ma[31] ? {32'd0, mb} : 64'd0);
            ma <= {ma[30:0], 1'b0};
          end
        end
      end
    end
  end

  `MSIS_ASSERT_NEXT(a_done_pulse, clk, rst, rsp.done, !rsp.done)
  `MSIS_ASSERT_IMP(a_count_range, clk, rst, busy, count <= 6'd32)
  `MSIS_ASSERT_NEXT(a_start_busy, clk, rst, req.start, busy)
endmodule
`default_nettype wire

>>> hw/rtl/mips_subset_instruction_step_core.sv
// Top level: one MIPS32 subset instruction executed per input word.
//
// Usage: s_axis carries one instruction word with the console value; m_axis
// returns one result word per executed instruction. cfg writes the start
// address and reloads the program counter; write it only while idle.
// Each word goes read (register file), execute (registered data store access,
// or multiply/divide start), then output: mult and div first wait for the
// 32-step multiply/divide unit, and the result word is registered in output.
// The next input word is taken the cycle after the result is registered,
// so no word is taken before the last one's result is registered. A stalled
// receiver holds at most one result while the next word is read; the
// block waits for m_axis_tready before registering another.
// Reset clears the data store one word per cycle, all DATA_WORDS words, during
// which no input word is taken; registers reset to zero with r28 and r29 set.
// After a stop trap or unknown trap, input words are accepted and dropped.
`default_nettype none
`include "mips_subset_instruction_step_core_macros.svh"
module mips_subset_instruction_step_core #(
  parameter int unsigned DATA_WORDS = msis_pkg::DataWordsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // instruction_word[31:0], entered_value[63:32]
  input  wire logic [63:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // instruction_address, next_address, write_valid, write_register,
  // write_value, console_event, console_value, halted, unimplemented, zero pad
  output logic [143:0]     m_axis_tdata
);
  localparam int unsigned AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

  msis_pkg::state_t state, state_next;
  logic [31:0] pc;
  logic [31:0] hi;
  logic [31:0] lo;
  logic        halt;
  logic [31:0] regs [32];
  logic [31:0] dmem [DATA_WORDS];
  logic [AW-1:0] clr_cnt;
  logic [31:0] ins;
  logic [31:0] entered;
  logic [31:0] ra;
  logic [31:0] rb;
  logic [31:0] dq;
  logic        dq_valid;
  logic [31:0] sl;
  logic [AW-1:0] lw_idx;

  msis_pkg::md_req_t md_req;
  msis_pkg::md_rsp_t md_rsp;

  msis_muldiv u_md (.clk(clk), .rst(rst), .req(md_req), .rsp(md_rsp));

  logic [5:0] op, fn;
  logic [4:0] rs, rt, rd, sh;
  logic [31:0] simm, next_pc, val, cval, seq;
  logic wr, unimpl, halt_now, do_sw;
  logic [4:0] dest;
  logic [1:0] ev;

  assign op = ins[31:26];
  assign fn = ins[5:0];
  assign rs = ins[25:21];
  assign rt = ins[20:16];
  assign rd = ins[15:11];
  assign sh = ins[10:6];
  assign simm = {{16{ins[15]}}, ins[15:0]};
  assign seq = pc + 32'd4;
  assign sl = ra + simm;

  always_comb begin
    next_pc = seq;
    wr = 1'b0;
    dest = 5'd0;
    val = 32'd0;
    ev = msis_pkg::EvNone;
    cval = 32'd0;
    unimpl = 1'b0;
    halt_now = 1'b0;
    do_sw = 1'b0;
    md_req.start = 1'b0;
    md_req.is_div = 1'b0;
    md_req.a = ra;
    md_req.b = rb;
    case (op)
      msis_pkg::OpSpecial: begin
        case (fn)
          msis_pkg::FnSll: begin wr = 1'b1; dest = rd; val = ra << sh; end
          msis_pkg::FnSra: begin
            wr = 1'b1; dest = rd; val = 32'($signed(ra) >>> sh);
          end
          msis_pkg::FnJr: next_pc = ra;
          msis_pkg::FnMfhi: begin wr = 1'b1; dest = rd; val = hi; end
          msis_pkg::FnMflo: begin wr = 1'b1; dest = rd; val = lo; end
          msis_pkg::FnMult: md_req.start = (state == msis_pkg::ST_EXEC);
          msis_pkg::FnDiv: begin
            md_req.start = (state == msis_pkg::ST_EXEC);
            md_req.is_div = 1'b1;
          end
          msis_pkg::FnAddu: begin wr = 1'b1; dest = rd; val = ra + rb; end
          msis_pkg::FnSubu: begin wr = 1'b1; dest = rd; val = ra - rb; end
          msis_pkg::FnSlt: begin
            wr = 1'b1; dest = rd;
            val = {31'd0, $signed(ra) < $signed(rb)};
          end
          default: unimpl = 1'b1;
        endcase
      end
      msis_pkg::OpJ: next_pc = {seq[31:28], ins[25:0], 2'b00};
      msis_pkg::OpJal: begin
        wr = 1'b1; dest = 5'd31; val = seq;
        next_pc = {seq[31:28], ins[25:0], 2'b00};
      end
      msis_pkg::OpBeq: if (ra == rb) next_pc = seq + {simm[29:0], 2'b00};
      msis_pkg::OpBne: if (ra != rb) next_pc = seq + {simm[29:0], 2'b00};
      msis_pkg::OpAddiu: begin wr = 1'b1; dest = rt; val = sl; end
      msis_pkg::OpAndi: begin wr = 1'b1; dest = rt; val = {16'd0, ins[15:0]} & ra; end
      msis_pkg::OpLui: begin wr = 1'b1; dest = rt; val = {ins[15:0], 16'd0}; end
      msis_pkg::OpTrap: begin
        case (ins[3:0])
          msis_pkg::TrapNewline: ev = msis_pkg::EvNewline;
          msis_pkg::TrapPrint: begin ev = msis_pkg::EvPrint; cval = ra; end
          msis_pkg::TrapRead: begin
            ev = msis_pkg::EvRead; wr = 1'b1; dest = rt; val = entered;
          end
          default: halt_now = 1'b1;
        endcase
      end
      msis_pkg::OpLw: begin wr = 1'b1; dest = rt; val = dq; end
      msis_pkg::OpSw: do_sw = 1'b1;
      default: unimpl = 1'b1;
    endcase
    if (!wr || dest == 5'd0) begin
      wr = 1'b0; dest = 5'd0; val = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= msis_pkg::ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_axis_tready = 1'b0;
    cfg_ready = (state == msis_pkg::ST_IDLE);
    case (state)
      msis_pkg::ST_CLEAR:
        if (clr_cnt == AW'(DATA_WORDS - 1)) state_next = msis_pkg::ST_IDLE;
      msis_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && !halt) state_next = msis_pkg::ST_READ;
      end
      msis_pkg::ST_READ: state_next = msis_pkg::ST_EXEC;
      msis_pkg::ST_EXEC:
        if (md_req.start) state_next = msis_pkg::ST_MUL;
        else state_next = msis_pkg::ST_OUT;
      msis_pkg::ST_MUL: if (md_rsp.done) state_next = msis_pkg::ST_OUT;
      msis_pkg::ST_OUT: if (!m_axis_tvalid || m_axis_tready) state_next = msis_pkg::ST_IDLE;
      default: state_next = msis_pkg::ST_IDLE;
    endcase
  end

  assign lw_idx = sl[AW+1:2];

  always_ff @(posedge clk) begin
    if (state == msis_pkg::ST_CLEAR) dmem[clr_cnt] <= 32'd0;
    else if (state == msis_pkg::ST_EXEC && do_sw) dmem[lw_idx] <= rb;
    dq <= dmem[lw_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      pc <= msis_pkg::StartReset;
      hi <= 32'd0;
      lo <= 32'd0;
      halt <= 1'b0;
      m_axis_tvalid <= 1'b0;
      dq_valid <= 1'b0;
      for (int i = 0; i < 32; i++) begin
        if (i == 28) regs[i] <= msis_pkg::GpReset;
        else if (i == 29) regs[i] <= msis_pkg::SpBase + 32'(DATA_WORDS * 4);
        else regs[i] <= 32'd0;
      end
    end else begin
      if (state == msis_pkg::ST_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (cfg_valid && cfg_ready) pc <= cfg_data;
      if (state == msis_pkg::ST_IDLE && s_axis_tvalid) begin
        ins <= s_axis_tdata[31:0];
        entered <= s_axis_tdata[63:32];
      end
      if (state == msis_pkg::ST_READ) begin
        ra <= regs[rs];
        rb <= regs[rt];
      end
      dq_valid <= (state == msis_pkg::ST_EXEC);
      if (md_rsp.done) begin
        hi <= md_rsp.hi;
        lo <= md_rsp.lo;
      end
      if (state == msis_pkg::ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        if (wr) regs[dest] <= val;
        if (halt_now) halt <= 1'b1;
        pc <= next_pc;
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= {6'd0, unimpl, halt_now, cval, ev, val, dest, wr, next_pc, pc};
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  `MSIS_ASSERT_IMP(a_no_accept_halted, clk, rst,
    s_axis_tvalid && s_axis_tready && halt, state_next == msis_pkg::ST_IDLE)
  `MSIS_ASSERT_IMP(a_cfg_idle, clk, rst, cfg_ready, state == msis_pkg::ST_IDLE)
  `MSIS_ASSERT_NEXT(a_lw_read, clk, rst, state == msis_pkg::ST_EXEC, dq_valid)
endmodule
`default_nettype wire
